// File: rtl/core/qipd_pkg.sv
package qipd_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned DATA_W    = 16;  // meas and goal fields
  localparam int unsigned GAIN_W    = 16;  // unsigned Q4.12 gains
  localparam int unsigned ERR_W     = 17;  // meas - goal
  localparam int unsigned DELTA_W   = 18;  // error - previous error
  localparam int unsigned PPROD_W   = 35;  // signed kp * delta
  localparam int unsigned IPROD_W   = 34;  // signed ki * error
  localparam int unsigned ACC_W     = 32;  // saturating accumulator
  localparam int unsigned FRAC_W    = 12;  // fraction bits of the gains
  localparam int unsigned TOTAL_W   = 45;  // accumulator scaled plus increment
  localparam int unsigned DUTY_W    = 13;  // PWM magnitude

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd32768;  // 8.0
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd3686;   // about 0.9

  // Load strobes for the three lane stages, driven by the top-level control.
  typedef struct packed {
    logic err_ld;   // capture error and delta, update previous error
    logic prod_ld;  // capture the gain products
    logic acc_ld;   // advance the accumulator
  } qipd_ld_t;

  // What one lane hands to the merge stage.
  typedef struct packed {
    logic              fwd;
    logic [DUTY_W-1:0] duty;
  } qipd_res_t;

endpackage

// File: rtl/core/qipd_lane.sv
// One wheel: error and delta, gain products, then the accumulator update with
// truncation toward zero and 32-bit saturation. The clamp to the drive limit
// works on the accumulator register directly.
module qipd_lane #(
  parameter int unsigned DRIVE_LIMIT = 7100
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  qipd_pkg::qipd_ld_t                  ld_i,
  input  logic signed [qipd_pkg::DATA_W-1:0]  meas_i,
  input  logic signed [qipd_pkg::DATA_W-1:0]  goal_i,
  input  logic        [qipd_pkg::GAIN_W-1:0]  prop_gain_i,
  input  logic        [qipd_pkg::GAIN_W-1:0]  integ_gain_i,
  output qipd_pkg::qipd_res_t                 res_o
);

  localparam logic signed [qipd_pkg::ACC_W-1:0] LimPos = qipd_pkg::ACC_W'(DRIVE_LIMIT);
  localparam logic signed [qipd_pkg::ACC_W-1:0] LimNeg = -LimPos;

  logic signed [qipd_pkg::ERR_W-1:0]   err_d;
  logic signed [qipd_pkg::ERR_W-1:0]   err_q;
  logic signed [qipd_pkg::ERR_W-1:0]   prev_err_q;
  logic signed [qipd_pkg::DELTA_W-1:0] delta_q;
  logic signed [qipd_pkg::PPROD_W-1:0] pprod_d, pprod_q;
  logic signed [qipd_pkg::IPROD_W-1:0] iprod_d, iprod_q;
  logic signed [qipd_pkg::TOTAL_W-1:0] total;
  logic signed [qipd_pkg::TOTAL_W-qipd_pkg::FRAC_W-1:0] whole;
  logic signed [qipd_pkg::ACC_W-1:0]   acc_d, acc_q;
  logic signed [qipd_pkg::ACC_W-1:0]   drive;
  logic signed [qipd_pkg::ACC_W-1:0]   mag;

  assign err_d = qipd_pkg::ERR_W'(meas_i) - qipd_pkg::ERR_W'(goal_i);

  // Stage one: error, delta and the previous error carried to the next tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_err_q <= '0;
    end else if (ld_i.err_ld) begin
      prev_err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.err_ld) begin
      err_q   <= err_d;
      delta_q <= qipd_pkg::DELTA_W'(err_d) - qipd_pkg::DELTA_W'(prev_err_q);
    end
  end

  // Stage two: the two gain products, one multiplier each.
  assign pprod_d = qipd_pkg::PPROD_W'($signed({1'b0, prop_gain_i}) * delta_q);
  assign iprod_d = qipd_pkg::IPROD_W'($signed({1'b0, integ_gain_i}) * err_q);

  always_ff @(posedge clk_i) begin
    if (ld_i.prod_ld) begin
      pprod_q <= pprod_d;
      iprod_q <= iprod_d;
    end
  end

  // Stage three: scaled accumulator plus increment, truncated toward zero.
  always_comb begin
    total = qipd_pkg::TOTAL_W'($signed({acc_q, {qipd_pkg::FRAC_W{1'b0}}}))
          + qipd_pkg::TOTAL_W'(pprod_q) + qipd_pkg::TOTAL_W'(iprod_q);
    whole = total[qipd_pkg::TOTAL_W-1:qipd_pkg::FRAC_W];
    // Arithmetic shift floors; a negative value with a fraction steps up by one.
    if (total[qipd_pkg::TOTAL_W-1] && (total[qipd_pkg::FRAC_W-1:0] != '0)) begin
      whole = whole + 1'b1;
    end
    if (whole[$high(whole)] != whole[qipd_pkg::ACC_W-1]) begin
      acc_d = whole[$high(whole)] ? {1'b1, {(qipd_pkg::ACC_W-1){1'b0}}}
                                  : {1'b0, {(qipd_pkg::ACC_W-1){1'b1}}};
    end else begin
      acc_d = whole[qipd_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ld_i.acc_ld) begin
      acc_q <= acc_d;
    end
  end

  // Clamp and split into magnitude and direction.
  always_comb begin
    priority if (acc_q > LimPos) begin
      drive = LimPos;
    end else if (acc_q < LimNeg) begin
      drive = LimNeg;
    end else begin
      drive = acc_q;
    end
    mag        = drive[qipd_pkg::ACC_W-1] ? -drive : drive;
    res_o.duty = mag[qipd_pkg::DUTY_W-1:0];
    res_o.fwd  = (drive > 0);
  end

endmodule

// File: rtl/core/qipd_merge.sv
// Gathers the lane results into one output word and holds it in the output
// register: all magnitudes first, then all direction bits, zero padded.
module qipd_merge #(
  parameter int unsigned LANES = 4,
  parameter int unsigned OUT_W = 56
) (
  input  logic                 clk_i,
  input  qipd_pkg::qipd_res_t  res_i [LANES],
  input  logic                 ld_i,
  output logic [OUT_W-1:0]     tdata_o
);

  logic [OUT_W-1:0] word_d;
  logic [OUT_W-1:0] word_q;

  always_comb begin
    word_d = '0;
    for (int l = 0; l < LANES; l++) begin
      word_d[l*qipd_pkg::DUTY_W +: qipd_pkg::DUTY_W] = res_i[l].duty;
      word_d[LANES*qipd_pkg::DUTY_W + l]            = res_i[l].fwd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      word_q <= word_d;
    end
  end

  assign tdata_o = word_q;

endmodule

// File: rtl/core/quad_incremental_pi_motor_drive.sv
// Incremental PI drive for LANES wheels, one lane per wheel.
//
// Input stream (s_axis): one word per control tick. tdata carries the signed
// 16-bit encoder counts of all wheels in the low half and the signed 16-bit
// target speeds in the high half. Output stream (m_axis): one word per input
// word with a 13-bit clamped magnitude per wheel followed by one direction
// bit per wheel (1 only for a strictly positive drive).
// Configuration: cfg_valid_i/cfg_addr_i/cfg_data_i write the gains. Indices
// 0..LANES-1 are the proportional gains, LANES..2*LANES-1 the integral gains,
// all unsigned Q4.12. Other indices are ignored. cfg_ready_o is always high;
// write only while no word is in flight.
// The accepting edge loads the error stage, and the product, accumulator and
// output registers follow in that order before m_axis_tvalid_o rises. A new
// word is accepted every cycle while the receiver does not stall; the
// accumulator update loops through one register per lane, which sets that rate.
// Each pipeline stage holds only when the stage after it is full and stalled,
// so a stalled receiver backs up the pipeline one stage at a time and
// s_axis_tready_o drops once all four stages hold words.
// Reset clears accumulators and previous errors to zero, restores the
// default gains and empties the pipeline.
module quad_incremental_pi_motor_drive #(
  parameter int unsigned LANES       = 4,
  parameter int unsigned DRIVE_LIMIT = 7100
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // fields from bit 0: meas_a..meas_d, goal_a..goal_d (16 bits each)
  input  logic [2*LANES*qipd_pkg::DATA_W-1:0]      s_axis_tdata_i,
  input  logic                                     s_axis_tvalid_i,
  output logic                                     s_axis_tready_o,
  // fields from bit 0: duty_a..duty_d (13 bits each), fwd_a..fwd_d, zero pad
  output logic [((LANES*(qipd_pkg::DUTY_W+1)+7)/8)*8-1:0] m_axis_tdata_o,
  output logic                                     m_axis_tvalid_o,
  input  logic                                     m_axis_tready_i,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [$clog2(2*LANES):0]                 cfg_addr_i,
  input  logic [qipd_pkg::GAIN_W-1:0]              cfg_data_i
);

  localparam int unsigned OutW  = ((LANES*(qipd_pkg::DUTY_W+1)+7)/8)*8;
  localparam int unsigned CfgAw = $clog2(2*LANES) + 1;

  logic [qipd_pkg::GAIN_W-1:0] prop_gain_q  [LANES];
  logic [qipd_pkg::GAIN_W-1:0] integ_gain_q [LANES];

  // Valid bits of the error, product and accumulator stages and the output.
  logic err_vld_q, prod_vld_q, acc_vld_q, out_vld_q;
  logic en_err, en_prod, en_acc, en_out;
  qipd_pkg::qipd_ld_t  ld;
  qipd_pkg::qipd_res_t lane_res [LANES];

  // Gain registers. The user must write only while the pipeline is empty; the block does not enforce this.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < LANES; l++) begin
        prop_gain_q[l]  <= qipd_pkg::PROP_GAIN_RST;
        integ_gain_q[l] <= qipd_pkg::INTEG_GAIN_RST;
      end
    end else if (cfg_valid_i) begin
      for (int l = 0; l < LANES; l++) begin
        if (cfg_addr_i == CfgAw'(l)) begin
          prop_gain_q[l] <= cfg_data_i;
        end
        if (cfg_addr_i == CfgAw'(LANES + l)) begin
          integ_gain_q[l] <= cfg_data_i;
        end
      end
    end
  end

  // A stage may load when it is empty or the next stage takes its word.
  assign en_out  = !out_vld_q || m_axis_tready_i;
  assign en_acc  = !acc_vld_q || en_out;
  assign en_prod = !prod_vld_q || en_acc;
  assign en_err  = !err_vld_q || en_prod;

  assign s_axis_tready_o = en_err;

  assign ld.err_ld  = en_err && s_axis_tvalid_i;
  assign ld.prod_ld = en_prod && err_vld_q;
  assign ld.acc_ld  = en_acc && prod_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_vld_q  <= 1'b0;
      prod_vld_q <= 1'b0;
      acc_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (en_err)  err_vld_q  <= s_axis_tvalid_i;
      if (en_prod) prod_vld_q <= err_vld_q;
      if (en_acc)  acc_vld_q  <= prod_vld_q;
      if (en_out)  out_vld_q  <= acc_vld_q;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    qipd_lane #(
      .DRIVE_LIMIT(DRIVE_LIMIT)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ld_i         (ld),
      .meas_i       (s_axis_tdata_i[l*qipd_pkg::DATA_W +: qipd_pkg::DATA_W]),
      .goal_i       (s_axis_tdata_i[(LANES+l)*qipd_pkg::DATA_W +: qipd_pkg::DATA_W]),
      .prop_gain_i  (prop_gain_q[l]),
      .integ_gain_i (integ_gain_q[l]),
      .res_o        (lane_res[l])
    );
  end

  qipd_merge #(
    .LANES(LANES),
    .OUT_W(OutW)
  ) u_merge (
    .clk_i   (clk_i),
    .res_i   (lane_res),
    .ld_i    (en_out && acc_vld_q),
    .tdata_o (m_axis_tdata_o)
  );

  assign m_axis_tvalid_o = out_vld_q;

  // An empty pipeline always takes a word.
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!err_vld_q && !prod_vld_q && !acc_vld_q && !out_vld_q) |-> s_axis_tready_o)
    else $error("pipeline empty but input not ready");

  // An accepted word occupies the error stage on the next cycle.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> err_vld_q)
    else $error("accepted word lost before the error stage");

  // A word in the accumulator stage that cannot move keeps the accumulator.
  a_acc_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_vld_q && !en_out) |=> acc_vld_q)
    else $error("accumulator stage dropped a stalled word");

endmodule
